// File: hw/rtl/hdwt_pkg.sv
// hdwt_pkg: shared types and constants of the 2-D Haar forward transform
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps

package hdwt_pkg;

  // fixed field widths of the channels
  localparam int unsigned PIXEL_W   = 8;
  localparam int unsigned COEFF_W   = 11;
  localparam int unsigned POS_W     = 9;
  localparam int unsigned SIZE_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;

  // reset value of both size registers
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(512);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 2'd0,
    CFG_FRAME_HEIGHT = 2'd1
  } cfg_idx_e;

  // coefficient order within one 2x2 block
  typedef enum logic [1:0] {
    BAND_LL = 2'd0,
    BAND_HL = 2'd1,
    BAND_LH = 2'd2,
    BAND_HH = 2'd3
  } band_e;

endpackage

// File: hw/rtl/hdwt_if.sv
// hdwt channel interfaces: pixel stream, coefficient stream, register writes
// depends on hdwt_pkg
`timescale 1ns / 1ps

interface hdwt_pix_if;
  import hdwt_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

interface hdwt_coef_if;
  import hdwt_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [COEFF_W-1:0] coeff_twice;
  logic [1:0]                band;
  logic [POS_W-1:0]          out_row;
  logic [POS_W-1:0]          out_col;
  logic                      last_of_block;
  logic                      end_of_frame;

  modport source (output valid, output coeff_twice, output band, output out_row,
                  output out_col, output last_of_block, output end_of_frame,
                  input ready);
  modport sink   (input valid, input coeff_twice, input band, input out_row,
                  input out_col, input last_of_block, input end_of_frame,
                  output ready);
endinterface

interface hdwt_cfg_if;
  import hdwt_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SIZE_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/haar_dwt_2d_forward.sv
// haar_dwt_2d_forward: one-level 2-D Haar forward transform over a raster pixel stream
// depends on hdwt_pkg, hdwt_if (channel interfaces) and hdwt_line_store
`timescale 1ns / 1ps

// Pixels enter in raster order; each even row is written into a line memory of
// MAX_WIDTH entries, and on an odd row the pixel of each even column is held
// while the memory is read for the upper pixels of the same 2x2 block. At the
// odd column the block is complete and four coefficients (LL, HL, LH, HH, each
// twice the orthonormal value, so exact) leave one per transfer with their
// quadrant position. On odd rows the output port carries one coefficient per
// cycle while the sink is ready, and a block yields four, so pixel intake
// waits on the output there. After the transfer of its last pixel a block is
// held in the block stage and then moved into the output buffer, which offers
// its first coefficient; the block stage waits while the buffer still holds
// coefficients of the previous block. The line memory never has a clearing
// pass: every entry read has been written in the preceding even row. Reads
// happen only in odd rows and writes only in even rows, so no forwarding is
// needed. Size registers may be written only while the block is idle; a new
// size applies at once to the counters.
module haar_dwt_2d_forward #(
  parameter int unsigned MAX_WIDTH  = 512,
  parameter int unsigned MAX_HEIGHT = 512,
  parameter int unsigned PIXEL_BITS = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  hdwt_cfg_if.sink    cfg_i,
  hdwt_pix_if.sink    pix_i,
  hdwt_coef_if.source coef_o
);
  import hdwt_pkg::*;

  // counter and clamped size widths
  localparam int unsigned CW   = $clog2(MAX_WIDTH);
  localparam int unsigned RW   = $clog2(MAX_HEIGHT);
  localparam int unsigned SZW  = ($clog2(MAX_WIDTH + 1) > SIZE_W) ?
                                 $clog2(MAX_WIDTH + 1) : SIZE_W;
  localparam int unsigned SZH  = ($clog2(MAX_HEIGHT + 1) > SIZE_W) ?
                                 $clog2(MAX_HEIGHT + 1) : SIZE_W;
  localparam int unsigned WMAX = (MAX_WIDTH / 2) * 2;
  localparam int unsigned HMAX = (MAX_HEIGHT / 2) * 2;
  // arithmetic width: wide enough for four pixels, never below the output
  localparam int unsigned CALCW = (PIXEL_BITS + 3 > COEFF_W) ? PIXEL_BITS + 3 : COEFF_W;

  // ---------------------------------------------------------------------------
  // size registers
  // ---------------------------------------------------------------------------
  logic [SIZE_W-1:0] width_q, height_q;
  logic [SZW-1:0]    w_even, w_eff;
  logic [SZH-1:0]    h_even, h_eff;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_RESET;
      height_q <= SIZE_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_FRAME_WIDTH:  width_q  <= cfg_i.data;
        CFG_FRAME_HEIGHT: height_q <= cfg_i.data;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // low bit dropped, then held between 2 and the even maximum
  always_comb begin
    w_even = SZW'({width_q[SIZE_W-1:1], 1'b0});
    h_even = SZH'({height_q[SIZE_W-1:1], 1'b0});
    w_eff  = w_even;
    h_eff  = h_even;
    if (w_even < SZW'(2)) begin
      w_eff = SZW'(2);
    end else if (w_even > SZW'(WMAX)) begin
      w_eff = SZW'(WMAX);
    end
    if (h_even < SZH'(2)) begin
      h_eff = SZH'(2);
    end else if (h_even > SZH'(HMAX)) begin
      h_eff = SZH'(HMAX);
    end
  end

  // ---------------------------------------------------------------------------
  // raster position and pixel intake
  // ---------------------------------------------------------------------------
  logic [CW-1:0]         col_q;
  logic [RW-1:0]         row_q;
  logic [PIXEL_BITS-1:0] left_q;
  logic [PIXEL_BITS-1:0] px;
  logic [SZW-1:0]        col_inc;
  logic [SZH-1:0]        row_inc;
  logic                  col_wrap, row_wrap;
  logic                  in_xfer;
  logic                  odd_row, odd_col;

  assign px       = PIXEL_BITS'(pix_i.pixel);
  assign col_inc  = SZW'(col_q) + SZW'(1);
  assign row_inc  = SZH'(row_q) + SZH'(1);
  assign col_wrap = (col_inc >= w_eff);
  assign row_wrap = (row_inc >= h_eff);
  assign odd_row  = row_q[0];
  assign odd_col  = col_q[0];
  assign in_xfer  = pix_i.valid && pix_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_xfer) begin
      if (col_wrap) begin
        col_q <= '0;
        row_q <= row_wrap ? '0 : RW'(row_inc);
      end else begin
        col_q <= CW'(col_inc);
      end
      // lower-left pixel of the block
      if (odd_row && !odd_col) begin
        left_q <= px;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // line memory: write on even rows, read the upper pixel on odd rows
  // the even-column read leaves a in the read register, the odd-column read b
  // ---------------------------------------------------------------------------
  logic                  ls_we, ls_re;
  logic [PIXEL_BITS-1:0] ls_rdata;

  assign ls_we = in_xfer && !odd_row;
  assign ls_re = in_xfer && odd_row;

  hdwt_line_store #(
    .DEPTH  (MAX_WIDTH),
    .DATA_W (PIXEL_BITS)
  ) u_line_store (
    .clk_i   (clk_i),
    .we_i    (ls_we),
    .re_i    (ls_re),
    .addr_i  (col_q),
    .wdata_i (px),
    .rdata_o (ls_rdata)
  );

  // ---------------------------------------------------------------------------
  // block stage: one complete 2x2 block waiting for b from the memory
  // ---------------------------------------------------------------------------
  logic                  blk_valid_q;
  logic [PIXEL_BITS-1:0] blk_a_q, blk_d_q;
  logic [POS_W-1:0]      blk_r0_q, blk_r1_q, blk_c0_q, blk_c1_q;
  logic                  blk_eof_q;
  logic                  blk_start;
  logic                  blk_load;

  logic                  ob_valid_q;
  band_e                 band_q;
  logic                  out_xfer;

  assign blk_start   = in_xfer && odd_row && odd_col;
  assign out_xfer    = coef_o.valid && coef_o.ready;
  assign blk_load    = blk_valid_q && (!ob_valid_q || (out_xfer && band_q == BAND_HH));
  // the block stage must be free: a held block still needs the memory read data
  assign pix_i.ready = !blk_valid_q || blk_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_valid_q <= 1'b0;
    end else if (blk_start) begin
      blk_valid_q <= 1'b1;
    end else if (blk_load) begin
      blk_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_start) begin
      blk_a_q   <= ls_rdata;
      blk_d_q   <= px;
      blk_r0_q  <= POS_W'(row_q >> 1);
      blk_c0_q  <= POS_W'(col_q >> 1);
      blk_r1_q  <= POS_W'(SZH'(h_eff >> 1) + SZH'(row_q >> 1));
      blk_c1_q  <= POS_W'(SZW'(w_eff >> 1) + SZW'(col_q >> 1));
      blk_eof_q <= col_wrap && row_wrap;
    end
  end

  // butterfly on the completed block, wrapping to the output width
  logic [CALCW-1:0]   op_a, op_b, op_c, op_d;
  logic [CALCW-1:0]   sum_ab, dif_ab, sum_cd, dif_cd;
  logic [COEFF_W-1:0] coef_d [4];

  always_comb begin
    op_a   = CALCW'(blk_a_q);
    op_b   = CALCW'(ls_rdata);
    op_c   = CALCW'(left_q);
    op_d   = CALCW'(blk_d_q);
    sum_ab = op_a + op_b;
    dif_ab = op_a - op_b;
    sum_cd = op_c + op_d;
    dif_cd = op_c - op_d;
    coef_d[BAND_LL] = COEFF_W'(sum_ab + sum_cd);
    coef_d[BAND_HL] = COEFF_W'(dif_ab + dif_cd);
    coef_d[BAND_LH] = COEFF_W'(sum_ab - sum_cd);
    coef_d[BAND_HH] = COEFF_W'(dif_ab - dif_cd);
  end

  // ---------------------------------------------------------------------------
  // output buffer: four coefficients of one block, sent LL, HL, LH, HH
  // ---------------------------------------------------------------------------
  logic [COEFF_W-1:0] ob_coef_q [4];
  logic [POS_W-1:0]   ob_r0_q, ob_r1_q, ob_c0_q, ob_c1_q;
  logic               ob_eof_q;
  logic               last_band;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ob_valid_q <= 1'b0;
      band_q     <= BAND_LL;
    end else if (blk_load) begin
      ob_valid_q <= 1'b1;
      band_q     <= BAND_LL;
    end else if (out_xfer) begin
      if (band_q == BAND_HH) begin
        ob_valid_q <= 1'b0;
      end
      band_q <= band_e'(band_q + 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (blk_load) begin
      ob_coef_q <= coef_d;
      ob_r0_q   <= blk_r0_q;
      ob_r1_q   <= blk_r1_q;
      ob_c0_q   <= blk_c0_q;
      ob_c1_q   <= blk_c1_q;
      ob_eof_q  <= blk_eof_q;
    end
  end

  // bottom half for LH and HH, right half for HL and HH
  assign last_band            = (band_q == BAND_HH);
  assign coef_o.valid         = ob_valid_q;
  assign coef_o.coeff_twice   = ob_coef_q[band_q];
  assign coef_o.band          = band_q;
  assign coef_o.out_row       = band_q[1] ? ob_r1_q : ob_r0_q;
  assign coef_o.out_col       = band_q[0] ? ob_c1_q : ob_c0_q;
  assign coef_o.last_of_block = last_band;
  assign coef_o.end_of_frame  = last_band && ob_eof_q;

endmodule

// File: hw/rtl/hdwt_line_store.sv
// hdwt_line_store: single-port line memory holding one even image row
// one write or one read per cycle, read data registered; no dependencies
`timescale 1ns / 1ps

module hdwt_line_store #(
  parameter int unsigned DEPTH  = 512,
  parameter int unsigned DATA_W = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    // read data holds until the next read
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/hdwt_checker.sv
// hdwt_checker: port-level assertions on the coefficient stream of the transform
// depends on hdwt_pkg; bound to haar_dwt_2d_forward at the end of this file
`timescale 1ns / 1ps

module hdwt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid,
  input logic        out_ready,
  input logic [10:0] out_coeff,
  input logic [1:0]  out_band,
  input logic        out_last,
  input logic        out_eof
);
  import hdwt_pkg::*;

  // a stalled coefficient holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_coeff) && $stable(out_band))
    else $error("stalled coefficient changed");

  // the four coefficients of a block leave without gaps and in band order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_ready && out_band != BAND_HH
      |=> out_valid && out_band == $past(out_band) + 2'd1)
    else $error("block coefficients out of order or interrupted");

  // block marker sits on the high-high coefficient only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_band == BAND_HH)))
    else $error("last_of_block not on the HH coefficient");

  // frame end only closes a block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_eof |-> out_last)
    else $error("end_of_frame outside a block end");

endmodule

bind haar_dwt_2d_forward hdwt_checker u_hdwt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (coef_o.valid),
  .out_ready (coef_o.ready),
  .out_coeff (coef_o.coeff_twice),
  .out_band  (coef_o.band),
  .out_last  (coef_o.last_of_block),
  .out_eof   (coef_o.end_of_frame)
);

// File: test/haar_dwt_2d_forward_test.sv
// haar_dwt_2d_forward_test: self-checking bench for the one-level 2-D Haar forward transform
// drives pixels and size writes over the hdwt channels and checks every coefficient transfer
// depends on hdwt_pkg, hdwt_if and the haar_dwt_2d_forward RTL
`timescale 1ns / 1ps

module haar_dwt_2d_forward_test;
  import hdwt_pkg::*;

  localparam int unsigned MAX_W = 512;
  localparam int unsigned MAX_H = 512;

  // idle percentages for the traffic phases
  localparam int unsigned IDLE_HEAVY = 46;
  localparam int unsigned IDLE_LIGHT = 15;

  // cycles allowed after the last coefficient before a size write, and run limit
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT   = 300000;
  localparam int unsigned RANDOM_PIXELS = 440;

  // register indexes the block does not decode
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // 2x2 blocks as {a, b, c, d}: every band at both ends of its range
  localparam logic [7:0][31:0] CORNER_BLOCKS = {
    32'hFFFF_FFFF,  // LL at its top
    32'h0000_0000,  // everything zero
    32'hFF00_FF00,  // HL at its top
    32'h00FF_00FF,  // HL at its bottom
    32'hFFFF_0000,  // LH at its top
    32'h0000_FFFF,  // LH at its bottom
    32'hFF00_00FF,  // HH at its top
    32'h00FF_FF00   // HH at its bottom
  };

  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SOURCE,
    IDLE_SINK,
    IDLE_BOTH
  } idle_mode_e;

  typedef struct packed {
    logic signed [COEFF_W-1:0] coeff;
    band_e                     band;
    logic [POS_W-1:0]          row;
    logic [POS_W-1:0]          col;
    logic                      last;
    logic                      eof;
  } coeff_t;

  // tracks the raster position, line store and sizes, and queues the coefficients due
  class haar_quad_tracker;
    logic [SIZE_W-1:0]  width_reg;
    logic [SIZE_W-1:0]  height_reg;
    logic [PIXEL_W-1:0] line_mem [MAX_W];
    logic [PIXEL_W-1:0] left_px;
    int unsigned        col_cnt;
    int unsigned        row_cnt;
    coeff_t             coeff_due [$];
    int unsigned        fault_count;

    function new();
      width_reg   = SIZE_RESET;
      height_reg  = SIZE_RESET;
      left_px     = '0;
      col_cnt     = 0;
      row_cnt     = 0;
      fault_count = 0;
      foreach (line_mem[i]) line_mem[i] = '0;
    endfunction

    // low bit dropped, at least 2, at most the largest even size
    function int unsigned even_size(logic [SIZE_W-1:0] v, int unsigned limit);
      int unsigned s;
      s = int'(v) & 32'hFFFF_FFFE;
      if (s < 2) s = 2;
      if (s > (limit & 32'hFFFF_FFFE)) s = limit & 32'hFFFF_FFFE;
      return s;
    endfunction

    function void write_size(logic [CFG_IDX_W-1:0] idx, logic [SIZE_W-1:0] value);
      if (idx == CFG_FRAME_WIDTH) width_reg = value;
      else if (idx == CFG_FRAME_HEIGHT) height_reg = value;
    endfunction

    function void queue_coeff(int v, band_e band, int unsigned r, int unsigned c,
                              logic last, logic eof);
      coeff_t e;
      e.coeff = COEFF_W'(v);
      e.band  = band;
      e.row   = POS_W'(r);
      e.col   = POS_W'(c);
      e.last  = last;
      e.eof   = eof;
      coeff_due.push_back(e);
    endfunction

    function void take_pixel(logic [PIXEL_W-1:0] px);
      int unsigned w, h, col, row, half_r, half_c;
      int          a, b, c, d;
      bit          col_wrap, row_wrap;
      w   = even_size(width_reg, MAX_W);
      h   = even_size(height_reg, MAX_H);
      col = col_cnt % MAX_W;
      row = row_cnt % MAX_H;
      // a size may shrink below the current position, so wrap on reaching or passing it
      col_wrap = (col + 1 >= w);
      row_wrap = (row + 1 >= h);
      if (row % 2 == 0) begin
        line_mem[col] = px;
      end else if (col % 2 == 0) begin
        left_px = px;
      end else begin
        a = line_mem[col - 1];
        b = line_mem[col];
        c = left_px;
        d = px;
        half_r = row / 2;
        half_c = col / 2;
        queue_coeff(a + b + c + d, BAND_LL, half_r, half_c, 1'b0, 1'b0);
        queue_coeff(a - b + c - d, BAND_HL, half_r, w / 2 + half_c, 1'b0, 1'b0);
        queue_coeff(a + b - c - d, BAND_LH, h / 2 + half_r, half_c, 1'b0, 1'b0);
        queue_coeff(a - b - c + d, BAND_HH, h / 2 + half_r, w / 2 + half_c, 1'b1,
                    col_wrap && row_wrap);
      end
      if (col_wrap) begin
        col_cnt = 0;
        row_cnt = row_wrap ? 0 : row + 1;
      end else begin
        col_cnt = col + 1;
        row_cnt = row;
      end
    endfunction

    function void report(string what);
      if (fault_count < 10) $display("%s", what);
      fault_count++;
    endfunction

    function void check_coeff(coeff_t got);
      coeff_t want;
      if (coeff_due.size() == 0) begin
        report($sformatf("coefficient %0d band %0d at (%0d,%0d) with none due",
                         $signed(got.coeff), got.band, got.row, got.col));
        return;
      end
      want = coeff_due.pop_front();
      if (got.coeff !== want.coeff || got.band !== want.band || got.row !== want.row ||
          got.col !== want.col || got.last !== want.last || got.eof !== want.eof) begin
        report($sformatf({"coefficient mismatch: expected %0d band %0d at (%0d,%0d) ",
                          "last %0b eof %0b, got %0d band %0d at (%0d,%0d) last %0b eof %0b"},
                         $signed(want.coeff), want.band, want.row, want.col, want.last,
                         want.eof, $signed(got.coeff), got.band, got.row, got.col,
                         got.last, got.eof));
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  hdwt_cfg_if  size_bus ();
  hdwt_pix_if  pix_bus ();
  hdwt_coef_if coef_bus ();

  haar_quad_tracker sb;
  int unsigned      gap_pct;
  int unsigned      stall_pct;
  int unsigned      cycle_count;

  haar_dwt_2d_forward #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H),
    .PIXEL_BITS (PIXEL_W)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (size_bus),
    .pix_i  (pix_bus),
    .coef_o (coef_bus)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("haar_dwt_2d_forward_test failed");
      $finish;
    end
  end

  // receiver stalls: a fresh choice every falling edge
  always @(negedge clk_i) begin
    coef_bus.ready = ($urandom_range(0, 99) >= stall_pct);
  end

  // every transfer seen at the rising edge: results first, then the pixel, then a size write
  always @(posedge clk_i) begin
    coeff_t got;
    if (rst_ni) begin
      if (coef_bus.valid && coef_bus.ready) begin
        got.coeff = coef_bus.coeff_twice;
        got.band  = band_e'(coef_bus.band);
        got.row   = coef_bus.out_row;
        got.col   = coef_bus.out_col;
        got.last  = coef_bus.last_of_block;
        got.eof   = coef_bus.end_of_frame;
        sb.check_coeff(got);
      end
      if (pix_bus.valid && pix_bus.ready) sb.take_pixel(pix_bus.pixel);
      if (size_bus.valid && size_bus.ready) sb.write_size(size_bus.index, size_bus.data);
    end
  end

  function automatic void set_idling(idle_mode_e mode);
    case (mode)
      IDLE_NONE: begin
        gap_pct   = 0;
        stall_pct = 0;
      end
      IDLE_SOURCE: begin
        gap_pct   = IDLE_HEAVY;
        stall_pct = 0;
      end
      IDLE_SINK: begin
        gap_pct   = 0;
        stall_pct = IDLE_HEAVY;
      end
      default: begin
        gap_pct   = IDLE_LIGHT;
        stall_pct = IDLE_LIGHT;
      end
    endcase
  endfunction

  // mostly small sizes, now and then odd, tiny or past the maximum
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return SIZE_W'($urandom_range(0, 16));
    if (r < 85) return SIZE_W'($urandom_range(17, 64));
    case ($urandom_range(0, 4))
      0:       return SIZE_W'(511);
      1:       return SIZE_W'(512);
      2:       return SIZE_W'(513);
      3:       return SIZE_W'(1023);
      default: return SIZE_W'($urandom_range(0, 1023));
    endcase
  endfunction

  // called and left at a falling edge; valid stays high for a back-to-back transfer
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    while ($urandom_range(0, 99) < gap_pct) begin
      pix_bus.valid = 1'b0;
      @(negedge clk_i);
    end
    pix_bus.valid = 1'b1;
    pix_bus.pixel = px;
    @(posedge clk_i);
    while (!pix_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SIZE_W-1:0] value);
    size_bus.valid = 1'b1;
    size_bus.index = idx;
    size_bus.data  = value;
    @(posedge clk_i);
    while (!size_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
    size_bus.valid = 1'b0;
  endtask

  // all coefficients in, then a few cycles for pixels still in the pipeline
  task automatic wait_drained();
    pix_bus.valid = 1'b0;
    while (sb.coeff_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    logic [PIXEL_W-1:0] px;
    int unsigned        n;
    int unsigned        phase;
    int unsigned        sent;

    rst_ni         = 1'b0;
    pix_bus.valid  = 1'b0;
    pix_bus.pixel  = '0;
    size_bus.valid = 1'b0;
    size_bus.index = '0;
    size_bus.data  = '0;
    coef_bus.ready = 1'b0;
    cycle_count    = 0;
    sb             = new();
    set_idling(IDLE_NONE);

    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // width below the minimum becomes 2; the block on rows 0 and 1 still sees the reset height
    write_reg(CFG_FRAME_WIDTH, SIZE_W'(1));
    repeat (4) send_pixel(PIXEL_W'($urandom_range(0, 255)));
    wait_drained();

    // height of zero becomes 2 while the counters already sit on row 2: that row is the last
    write_reg(CFG_FRAME_HEIGHT, SIZE_W'(0));
    repeat (2) send_pixel(PIXEL_W'($urandom_range(0, 255)));
    wait_drained();

    // one-block frames at the extremes of every band
    for (int k = 0; k < 8; k++) begin
      if (k == 2) begin
        // odd sizes lose their low bit
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(3));
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(3));
      end
      if (k == 4) begin
        // undecoded indexes must leave both sizes alone
        write_reg(REG_SPARE_2, SIZE_W'(1023));
        write_reg(REG_SPARE_3, SIZE_W'(0));
      end
      set_idling(idle_mode_e'(k % 4));
      for (int j = 3; j >= 0; j--) send_pixel(CORNER_BLOCKS[k][8*j +: 8]);
      wait_drained();
    end

    // random phases: sizes change between phases, often in mid-frame, under each idle mode;
    // the width only changes on an even row, so an odd row never reads an unwritten entry
    phase = 0;
    sent  = 0;
    while (sent < RANDOM_PIXELS) begin
      if (phase == 0) begin
        // narrowest width with the height saturated to its maximum
        write_reg(CFG_FRAME_WIDTH, SIZE_W'(2));
        write_reg(CFG_FRAME_HEIGHT, SIZE_W'(1023));
      end else begin
        if ($urandom_range(0, 2) == 0 && sb.row_cnt % 2 == 0) begin
          write_reg(CFG_FRAME_WIDTH, pick_size());
        end
        if ($urandom_range(0, 2) == 0) write_reg(CFG_FRAME_HEIGHT, pick_size());
        if ($urandom_range(0, 7) == 0) begin
          write_reg($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
                    SIZE_W'($urandom_range(0, 1023)));
        end
      end
      set_idling(idle_mode_e'(phase % 4));
      n = $urandom_range(4, 48);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 7) == 0) px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        else px = PIXEL_W'($urandom_range(0, 255));
        send_pixel(px);
      end
      sent += n;
      phase++;
      wait_drained();
    end

    // catch any stray coefficient after the last one due
    set_idling(IDLE_NONE);
    repeat (4 * SETTLE_CYCLES) @(negedge clk_i);
    if (sb.fault_count == 0 && sb.coeff_due.size() == 0) begin
      $display("haar_dwt_2d_forward_test passed");
    end else begin
      $display("haar_dwt_2d_forward_test failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/hdwt_pkg.sv
hw/rtl/hdwt_if.sv
hw/rtl/hdwt_line_store.sv
hw/rtl/haar_dwt_2d_forward.sv
hw/rtl/hdwt_checker.sv
test/haar_dwt_2d_forward_test.sv
